/* hw/rtl/ccix_pkg.sv */
// shared types and constants of the commodity channel index block
`default_nettype none
package ccix_pkg;

  localparam int unsigned MAX_WINDOW = 256;
  localparam int unsigned PRICE_BITS = 24;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned CFG_RESET  = 20;
  localparam int unsigned SCALE_NUM  = 51200;
  localparam int unsigned OUT_W      = 32;

  localparam int unsigned AW    = $clog2(MAX_WINDOW);
  localparam int unsigned NW    = AW + 1;
  localparam int unsigned LW    = (NW > CFG_W) ? NW : CFG_W;
  localparam int unsigned TW    = PRICE_BITS + 2;
  localparam int unsigned SW    = TW + AW;
  localparam int unsigned VW    = TW + NW;
  localparam int unsigned DW    = VW + AW;
  localparam int unsigned DENW  = DW + 2;
  localparam int unsigned RW    = DENW + 2;
  localparam int unsigned KBITS = $clog2(MAX_WINDOW * SCALE_NUM + 1);
  localparam int unsigned KIW   = $clog2(KBITS);

  typedef struct packed {
    logic [PRICE_BITS-1:0] high_price;
    logic [PRICE_BITS-1:0] low_price;
    logic [PRICE_BITS-1:0] close_price;
  } bar_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] index_value;
    logic                    window_full;
  } result_t;

endpackage
`default_nettype wire

/* hw/rtl/ccix_ram.sv */
// generic single write, single read ram with registered read data
`default_nettype none
module ccix_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/commodity_channel_index.sv */
// commodity channel index over a sliding window of price bars
// usage:
//   a bar request (high, low, close) enters on in_valid_i/in_ready_o and gives
//   exactly one result on out_valid_o/out_ready_i. window_length is written
//   through cfg_we_i/cfg_wdata_i while the block is idle; 0 acts as 1 and
//   values above 256 act as 256.
// processing:
//   one bar at a time. a bar that fills the window makes two passes over the
//   typical-price ring through the single read port of the ring memory,
//   followed by a 24 step shift and subtract scaling divider, which is
//   skipped when the deviation sum is zero. a bar that leaves the window
//   short skips the passes and the divider.
// reset:
//   rst_ni clears the write slot, the bar count and the output valid flag and
//   sets window_length to 20. the ring memory itself is not cleared.
// stalls:
//   a finished result waits in the output register; the next bar is taken
//   and processed meanwhile and waits for the register to drain.
`default_nettype none
module commodity_channel_index
  import ccix_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire bar_t             in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output result_t               out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_SUM, S_DEV, S_SCALE, S_PREP, S_DIV, S_OUT
  } state_e;

  state_e            state_q;
  logic [CFG_W-1:0]  wlen_q;
  logic [AW-1:0]     pos_q, base_q;
  logic [NW-1:0]     seen_q, n_q, cnt_q;
  logic [TW-1:0]     tc_q;
  logic [SW-1:0]     sum_q;
  logic [VW-1:0]     prod_q, diff_q, ntc_q, num_q;
  logic [DW-1:0]     dev_q;
  logic [DENW-1:0]   den_q;
  logic [KBITS-1:0]  k_q, q_q;
  logic [KIW-1:0]    kb_q;
  logic [RW-1:0]     r_q;
  logic              neg_q, rd_vld_q, prod_vld_q, diff_vld_q;
  result_t           res_q, out_q;
  logic              out_valid_q;

  logic [TW-1:0]     rdata;
  logic              issue;
  logic [AW-1:0]     raddr;
  logic [LW-1:0]     wlen_ext;
  logic [NW-1:0]     n_eff, seen_d;
  logic [VW-1:0]     sum_ext;
  logic [RW-1:0]     r_sh, den_ext, r_next;
  logic [1:0]        qbits;
  logic [KBITS-1:0]  q_next;
  logic [OUT_W:0]    mag;
  logic              accept;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  assign wlen_ext = LW'(wlen_q);
  always_comb begin
    if (wlen_ext == '0) begin
      n_eff = NW'(1);
    end else if (wlen_ext > LW'(MAX_WINDOW)) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(wlen_ext);
    end
  end

  assign seen_d = (seen_q < NW'(MAX_WINDOW)) ? seen_q + NW'(1) : seen_q;

  assign issue = ((state_q == S_SUM) || (state_q == S_DEV)) && (cnt_q < n_q);
  assign raddr = base_q - cnt_q[AW-1:0];
  assign sum_ext = VW'(sum_q);

  assign den_ext = RW'(den_q);
  assign r_sh = {r_q[RW-2:0], 1'b0} + (k_q[kb_q] ? RW'(num_q) : RW'(0));
  always_comb begin
    if (r_sh >= {den_ext[RW-2:0], 1'b0}) begin
      r_next = r_sh - {den_ext[RW-2:0], 1'b0};
      qbits  = 2'd2;
    end else if (r_sh >= den_ext) begin
      r_next = r_sh - den_ext;
      qbits  = 2'd1;
    end else begin
      r_next = r_sh;
      qbits  = 2'd0;
    end
  end
  assign q_next = {q_q[KBITS-2:0], 1'b0} + KBITS'(qbits);
  assign mag = (OUT_W + 1)'(q_next);

  ccix_ram #(
    .WIDTH(TW),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (state_q == S_WRITE),
    .waddr_i(base_q),
    .wdata_i(tc_q),
    .re_i   (issue),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wlen_q      <= CFG_W'(CFG_RESET);
      pos_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      diff_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q && (state_q == S_DEV);
      diff_vld_q <= prod_vld_q;
      if (issue) begin
        cnt_q <= cnt_q + NW'(1);
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            tc_q    <= TW'(in_data_i.high_price) + TW'(in_data_i.low_price)
                       + TW'(in_data_i.close_price);
            base_q  <= pos_q;
            pos_q   <= pos_q + AW'(1);
            seen_q  <= seen_d;
            n_q     <= n_eff;
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          cnt_q <= '0;
          sum_q <= '0;
          if (seen_q < n_q) begin
            res_q   <= '{index_value: '0, window_full: 1'b0};
            state_q <= S_OUT;
          end else begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          if (rd_vld_q) begin
            sum_q <= sum_q + SW'(rdata);
          end
          if (cnt_q == n_q && !rd_vld_q) begin
            cnt_q   <= '0;
            dev_q   <= '0;
            state_q <= S_DEV;
          end
        end
        S_DEV: begin
          prod_q <= VW'(n_q) * VW'(rdata);
          diff_q <= (prod_q >= sum_ext) ? prod_q - sum_ext : sum_ext - prod_q;
          if (diff_vld_q) begin
            dev_q <= dev_q + DW'(diff_q);
          end
          if (cnt_q == n_q && !rd_vld_q && !prod_vld_q && !diff_vld_q) begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          ntc_q <= VW'(n_q) * VW'(tc_q);
          k_q   <= KBITS'(n_q) * KBITS'(SCALE_NUM);
          den_q <= DENW'(dev_q) + (DENW'(dev_q) << 1);
          if (dev_q == '0) begin
            res_q   <= '{index_value: '0, window_full: 1'b1};
            state_q <= S_OUT;
          end else begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          neg_q   <= ntc_q < sum_ext;
          num_q   <= (ntc_q < sum_ext) ? sum_ext - ntc_q : ntc_q - sum_ext;
          r_q     <= '0;
          q_q     <= '0;
          kb_q    <= KIW'(KBITS - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          r_q  <= r_next;
          q_q  <= q_next;
          kb_q <= kb_q - KIW'(1);
          if (kb_q == '0) begin
            res_q.window_full <= 1'b1;
            if (neg_q) begin
              res_q.index_value <= (mag > {1'b0, 1'b1, {(OUT_W-1){1'b0}}}) ?
                                   {1'b1, {(OUT_W-1){1'b0}}} : -mag[OUT_W-1:0];
            end else begin
              res_q.index_value <= (mag > {2'b00, {(OUT_W-1){1'b1}}}) ?
                                   {1'b0, {(OUT_W-1){1'b1}}} : mag[OUT_W-1:0];
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ccix_checker.sv */
// port-level checks of the commodity channel index block and their binding
`default_nettype none
module ccix_assertions
  import ccix_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire result_t          out_data_o
);

  // result request holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // short window gives a zero index
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.window_full |-> out_data_o.index_value == '0)
    else $error("nonzero index with window not full");

  // one bar in flight at a time
  a_one_bar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second bar taken while busy");

  // a result cannot appear in the cycle right after a bar is taken
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result without processing time");

endmodule

bind commodity_channel_index ccix_assertions u_ccix_assertions (.*);
`default_nettype wire
